// File: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

    localparam int NUM_BLOCKS_DEF  = 16;
    localparam int NUM_THREADS_DEF = 4;
    localparam int HEAP_W          = 17;
    localparam int OFF_W           = 16;
    localparam int ALU_W           = 18;
    localparam logic [HEAP_W-1:0] HEAP_RESET = 17'd4096;
    localparam logic [HEAP_W-1:0] HEAP_MAX   = 17'd65536;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_REQ  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [1:0]        thread;
        logic [HEAP_W-1:0] request_size;
        logic [OFF_W-1:0]  block_address;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  address;
        logic [HEAP_W-1:0] granted_size;
    } res_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic [ALU_W-1:0] diff;
        logic             ge;
        logic             eq;
    } alu_out_t;

endpackage
`default_nettype wire

// File: rtl/ffba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/ffba_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_alu import ffba_pkg::*; (
    input  wire logic [ALU_W-1:0] a,
    input  wire logic [ALU_W-1:0] b,
    output alu_out_t              y
);
    always_comb
    begin
        y.sum  = a + b;
        y.diff = a - b;
        y.ge   = (a >= b);
        y.eq   = (a == b);
    end
endmodule
`default_nettype wire

// File: rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator with one descriptor table per thread. A command is
// taken when start is high and busy is low; its single result appears on
// result with done high for exactly one cycle and must be captured then, the
// block cannot be held off. Init and rejected commands finish straight from
// idle. Allocate and free scan the thread's descriptor table through one
// memory port, one descriptor per cycle, followed by update states that
// write the chosen descriptor and fix neighbour links. A single shared
// add/compare unit does the size and offset arithmetic of the scan and
// update states. The heap size register is written through cfg_we/cfg_wdata.
module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int NUM_THREADS = NUM_THREADS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire cmd_t              cmd,
    output logic                   busy,
    output logic                   done,
    output res_t                   result,
    input  wire logic              cfg_we,
    input  wire logic [HEAP_W-1:0] cfg_wdata
);
    localparam int DEPTH  = NUM_BLOCKS * NUM_THREADS;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
    localparam int TH_W   = NUM_THREADS > 1 ? $clog2(NUM_THREADS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam int ENT_W  = OFF_W + HEAP_W + 2 * LINK_W;
    localparam logic [LINK_W-1:0] LINK_NONE = '1;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SCAN   = 12'b000000000010,
        S_DECIDE = 12'b000000000100,
        S_WSPARE = 12'b000000001000,
        S_RDFIX  = 12'b000000010000,
        S_FIX    = 12'b000000100000,
        S_WPICK  = 12'b000001000000,
        S_CHKN   = 12'b000010000000,
        S_MRGN   = 12'b000100000000,
        S_CHKP   = 12'b001000000000,
        S_MRGP   = 12'b010000000000,
        S_WKEEP  = 12'b100000000000
    } state_t;

    state_t              state_reg, state_next, fix_ret_reg, fix_ret_next;
    logic                alloc_reg, alloc_next;
    logic [TH_W-1:0]     t_reg, t_next;
    logic [ALU_W-1:0]    need_reg, need_next;
    logic [OFF_W-1:0]    where_reg, where_next;
    logic [IDX_W:0]      cnt_reg, cnt_next;
    logic                chk_reg, chk_next;
    logic [IDX_W-1:0]    sidx_reg, sidx_next;
    logic                found_reg, found_next;
    logic                sparef_reg, sparef_next;
    logic [IDX_W-1:0]    spare_reg, spare_next;
    logic [IDX_W-1:0]    k_idx_reg, k_idx_next;
    logic [OFF_W-1:0]    k_off_reg, k_off_next;
    logic [HEAP_W-1:0]   k_size_reg, k_size_next;
    logic [LINK_W-1:0]   k_prev_reg, k_prev_next;
    logic [LINK_W-1:0]   k_next_reg, k_next_next;
    logic [HEAP_W-1:0]   rem_reg, rem_next;
    logic [IDX_W-1:0]    fix_tgt_reg, fix_tgt_next;
    logic [LINK_W-1:0]   fix_link_reg, fix_link_next;
    logic [DEPTH-1:0]    act_reg, act_next;
    logic [DEPTH-1:0]    used_reg, used_next;
    logic [HEAP_W-1:0]   heap_reg, heap_next;
    logic                done_reg, done_next;
    res_t                res_reg, res_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENT_W-1:0]    ram_wdata, ram_rdata;
    logic [OFF_W-1:0]    rd_off;
    logic [HEAP_W-1:0]   rd_size;
    logic [LINK_W-1:0]   rd_prev, rd_next;
    logic [ALU_W-1:0]    alu_a, alu_b;
    alu_out_t            alu_y;

    function automatic logic [ADDR_W-1:0] ent_addr(input int th, input int ix);
        return ADDR_W'(th * NUM_BLOCKS + ix);
    endfunction

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < LINK_W'(NUM_BLOCKS);
    endfunction

    ffba_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ffba_alu u_alu (
        .a (alu_a),
        .b (alu_b),
        .y (alu_y)
    );

    assign {rd_off, rd_size, rd_prev, rd_next} = ram_rdata;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        logic a_act;
        logic a_used;
        logic [IDX_W-1:0] lidx;
        state_next    = state_reg;
        fix_ret_next  = fix_ret_reg;
        alloc_next    = alloc_reg;
        t_next        = t_reg;
        need_next     = need_reg;
        where_next    = where_reg;
        cnt_next      = cnt_reg;
        chk_next      = chk_reg;
        sidx_next     = sidx_reg;
        found_next    = found_reg;
        sparef_next   = sparef_reg;
        spare_next    = spare_reg;
        k_idx_next    = k_idx_reg;
        k_off_next    = k_off_reg;
        k_size_next   = k_size_reg;
        k_prev_next   = k_prev_reg;
        k_next_next   = k_next_reg;
        rem_next      = rem_reg;
        fix_tgt_next  = fix_tgt_reg;
        fix_link_next = fix_link_reg;
        act_next      = act_reg;
        used_next     = used_reg;
        heap_next     = cfg_we ? cfg_wdata : heap_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_addr      = '0;
        ram_wdata     = '0;
        alu_a         = '0;
        alu_b         = '0;
        a_act         = 1'b0;
        a_used        = 1'b0;
        lidx          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    t_next     = TH_W'(cmd.thread);
                    need_next  = (ALU_W'(cmd.request_size) + ALU_W'(7)) & ~ALU_W'(7);
                    where_next = cmd.block_address;
                    alloc_next = (cmd.operation == OP_ALLOC);
                    cnt_next   = '0;
                    chk_next   = 1'b0;
                    found_next = 1'b0;
                    sparef_next = 1'b0;
                    res_next   = '{status: ST_BAD_REQ, address: '0, granted_size: '0};
                    if (int'(cmd.thread) >= NUM_THREADS)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        case (op_t'(cmd.operation))
                            OP_INIT:
                            begin
                                done_next = 1'b1;
                                if (heap_reg != '0)
                                begin
                                    ram_we    = 1'b1;
                                    ram_addr  = ent_addr(int'(cmd.thread), 0);
                                    ram_wdata = {OFF_W'(0),
                                                 (heap_reg > HEAP_MAX) ? HEAP_MAX : heap_reg,
                                                 LINK_NONE, LINK_NONE};
                                    for (int j = 0; j < NUM_BLOCKS; j++)
                                    begin
                                        act_next[ent_addr(int'(cmd.thread), j)]  = 1'b0;
                                        used_next[ent_addr(int'(cmd.thread), j)] = 1'b0;
                                    end
                                    act_next[ent_addr(int'(cmd.thread), 0)] = 1'b1;
                                    res_next.status = ST_OK;
                                end
                            end
                            OP_ALLOC:
                            begin
                                if (cmd.request_size == '0)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                            OP_FREE:
                            begin
                                state_next = S_SCAN;
                            end
                            default:
                            begin
                                done_next = 1'b1;
                            end
                        endcase
                    end
                end
            end

            S_SCAN:
            begin
                // read issued for cnt, data checked in the next cycle for sidx
                if (cnt_reg < (IDX_W + 1)'(NUM_BLOCKS))
                begin
                    ram_addr  = ent_addr(int'(t_reg), int'(cnt_reg[IDX_W-1:0]));
                    cnt_next  = cnt_reg + 1'b1;
                    chk_next  = 1'b1;
                    sidx_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    chk_next = 1'b0;
                end
                if (chk_reg)
                begin
                    a_act  = act_reg[ent_addr(int'(t_reg), int'(sidx_reg))];
                    a_used = used_reg[ent_addr(int'(t_reg), int'(sidx_reg))];
                    alu_a  = alloc_reg ? ALU_W'(rd_size) : ALU_W'(rd_off);
                    alu_b  = alloc_reg ? need_reg : ALU_W'(where_reg);
                    if (!found_reg && a_act && (alloc_reg ? (!a_used && alu_y.ge)
                                                          : (a_used && alu_y.eq)))
                    begin
                        found_next  = 1'b1;
                        k_idx_next  = sidx_reg;
                        k_off_next  = rd_off;
                        k_size_next = rd_size;
                        k_prev_next = rd_prev;
                        k_next_next = rd_next;
                    end
                    if (alloc_reg && !sparef_reg && !a_act)
                    begin
                        sparef_next = 1'b1;
                        spare_next  = sidx_reg;
                    end
                    if (sidx_reg == IDX_W'(NUM_BLOCKS - 1))
                    begin
                        if (alloc_reg)
                        begin
                            state_next = S_DECIDE;
                        end
                        else if (found_next)
                        begin
                            state_next = S_CHKN;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                            res_next   = '{status: ST_NOT_FOUND, address: '0,
                                           granted_size: '0};
                        end
                    end
                end
            end

            S_DECIDE:
            begin
                alu_a = ALU_W'(k_size_reg);
                alu_b = need_reg;
                if (!found_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = '{status: ST_NO_FIT, address: '0, granted_size: '0};
                end
                else if (alu_y.ge && !alu_y.eq && sparef_reg)
                begin
                    rem_next    = alu_y.diff[HEAP_W-1:0];
                    k_size_next = need_reg[HEAP_W-1:0];
                    state_next  = S_WSPARE;
                end
                else
                begin
                    state_next = S_WPICK;
                end
            end

            S_WSPARE:
            begin
                alu_a     = ALU_W'(k_off_reg);
                alu_b     = need_reg;
                ram_we    = 1'b1;
                ram_addr  = ent_addr(int'(t_reg), int'(spare_reg));
                ram_wdata = {alu_y.sum[OFF_W-1:0], rem_reg, {1'b0, k_idx_reg}, k_next_reg};
                act_next[ent_addr(int'(t_reg), int'(spare_reg))]  = 1'b1;
                used_next[ent_addr(int'(t_reg), int'(spare_reg))] = 1'b0;
                k_next_next = {1'b0, spare_reg};
                if (link_ok(k_next_reg))
                begin
                    fix_tgt_next  = k_next_reg[IDX_W-1:0];
                    fix_link_next = {1'b0, spare_reg};
                    fix_ret_next  = S_WPICK;
                    state_next    = S_RDFIX;
                end
                else
                begin
                    state_next = S_WPICK;
                end
            end

            S_RDFIX:
            begin
                ram_addr   = ent_addr(int'(t_reg), int'(fix_tgt_reg));
                state_next = S_FIX;
            end

            S_FIX:
            begin
                // rewrite the neighbor's back link only
                ram_we     = 1'b1;
                ram_addr   = ent_addr(int'(t_reg), int'(fix_tgt_reg));
                ram_wdata  = {rd_off, rd_size, fix_link_reg, rd_next};
                state_next = fix_ret_reg;
            end

            S_WPICK:
            begin
                ram_we    = 1'b1;
                ram_addr  = ent_addr(int'(t_reg), int'(k_idx_reg));
                ram_wdata = {k_off_reg, k_size_reg, k_prev_reg, k_next_reg};
                used_next[ent_addr(int'(t_reg), int'(k_idx_reg))] = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
                res_next   = '{status: ST_OK, address: k_off_reg, granted_size: k_size_reg};
            end

            S_CHKN:
            begin
                lidx   = k_next_reg[IDX_W-1:0];
                a_act  = act_reg[ent_addr(int'(t_reg), int'(lidx))];
                a_used = used_reg[ent_addr(int'(t_reg), int'(lidx))];
                if (link_ok(k_next_reg) && a_act && !a_used)
                begin
                    ram_addr   = ent_addr(int'(t_reg), int'(lidx));
                    state_next = S_MRGN;
                end
                else
                begin
                    state_next = S_CHKP;
                end
            end

            S_MRGN:
            begin
                lidx        = k_next_reg[IDX_W-1:0];
                alu_a       = ALU_W'(k_size_reg);
                alu_b       = ALU_W'(rd_size);
                k_size_next = alu_y.sum[HEAP_W-1:0];
                k_next_next = rd_next;
                act_next[ent_addr(int'(t_reg), int'(lidx))]  = 1'b0;
                used_next[ent_addr(int'(t_reg), int'(lidx))] = 1'b0;
                if (link_ok(rd_next))
                begin
                    fix_tgt_next  = rd_next[IDX_W-1:0];
                    fix_link_next = {1'b0, k_idx_reg};
                    fix_ret_next  = S_CHKP;
                    state_next    = S_RDFIX;
                end
                else
                begin
                    state_next = S_CHKP;
                end
            end

            S_CHKP:
            begin
                lidx   = k_prev_reg[IDX_W-1:0];
                a_act  = act_reg[ent_addr(int'(t_reg), int'(lidx))];
                a_used = used_reg[ent_addr(int'(t_reg), int'(lidx))];
                if (link_ok(k_prev_reg) && a_act && !a_used)
                begin
                    ram_addr   = ent_addr(int'(t_reg), int'(lidx));
                    state_next = S_MRGP;
                end
                else
                begin
                    state_next = S_WKEEP;
                end
            end

            S_MRGP:
            begin
                // left neighbor becomes the surviving descriptor
                alu_a       = ALU_W'(rd_size);
                alu_b       = ALU_W'(k_size_reg);
                k_size_next = alu_y.sum[HEAP_W-1:0];
                k_off_next  = rd_off;
                k_prev_next = rd_prev;
                k_idx_next  = k_prev_reg[IDX_W-1:0];
                act_next[ent_addr(int'(t_reg), int'(k_idx_reg))]  = 1'b0;
                used_next[ent_addr(int'(t_reg), int'(k_idx_reg))] = 1'b0;
                if (link_ok(k_next_reg))
                begin
                    fix_tgt_next  = k_next_reg[IDX_W-1:0];
                    fix_link_next = k_prev_reg;
                    fix_ret_next  = S_WKEEP;
                    state_next    = S_RDFIX;
                end
                else
                begin
                    state_next = S_WKEEP;
                end
            end

            S_WKEEP:
            begin
                ram_we    = 1'b1;
                ram_addr  = ent_addr(int'(t_reg), int'(k_idx_reg));
                ram_wdata = {k_off_reg, k_size_reg, k_prev_reg, k_next_reg};
                used_next[ent_addr(int'(t_reg), int'(k_idx_reg))] = 1'b0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                res_next   = '{status: ST_OK, address: '0, granted_size: '0};
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fix_ret_reg <= S_IDLE;
            cnt_reg     <= '0;
            chk_reg     <= 1'b0;
            found_reg   <= 1'b0;
            sparef_reg  <= 1'b0;
            act_reg     <= '0;
            used_reg    <= '0;
            heap_reg    <= HEAP_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fix_ret_reg <= fix_ret_next;
            cnt_reg     <= cnt_next;
            chk_reg     <= chk_next;
            found_reg   <= found_next;
            sparef_reg  <= sparef_next;
            act_reg     <= act_next;
            used_reg    <= used_next;
            heap_reg    <= heap_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alloc_reg    <= alloc_next;
        t_reg        <= t_next;
        need_reg     <= need_next;
        where_reg    <= where_next;
        sidx_reg     <= sidx_next;
        spare_reg    <= spare_next;
        k_idx_reg    <= k_idx_next;
        k_off_reg    <= k_off_next;
        k_size_reg   <= k_size_next;
        k_prev_reg   <= k_prev_next;
        k_next_reg   <= k_next_next;
        rem_reg      <= rem_next;
        fix_tgt_reg  <= fix_tgt_next;
        fix_link_reg <= fix_link_next;
        res_reg      <= res_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction dropped");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.address == '0 && result.granted_size == '0))
        else $error("failed transaction carries nonzero payload");

endmodule
`default_nettype wire
